@@ hdl/tsfc_pkg.sv @@
// Package for the true-stereo FIR convolver: sizes, item codes and the
// command and status structs between controller and datapath.
// Depends on nothing.
package tsfc_pkg;

  localparam int MAX_TAPS    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int FIELD_W     = 16;
  localparam int TAPS_W      = 9;
  localparam int TAP_AW      = $clog2(MAX_TAPS);
  localparam int CNT_W       = TAP_AW + 1;
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W       = PROD_W + TAP_AW + 1;
  localparam int GAIN_W      = 16;
  localparam int SCALED_W    = ACC_W + GAIN_W;
  localparam int OUT_SHIFT   = SAMPLE_BITS + COEF_BITS - 2;
  localparam int SHIFTED_W   = SCALED_W - OUT_SHIFT;
  localparam int OUT_W       = 16;

  localparam logic signed [GAIN_W-1:0] GAIN_Q15 = 16'sd11469;
  localparam logic [TAPS_W-1:0] TAPS_RESET = 9'd256;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_COEF   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] PATH_LL = 2'd0;
  localparam logic [1:0] PATH_LR = 2'd1;
  localparam logic [1:0] PATH_RL = 2'd2;
  localparam logic [1:0] PATH_RR = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic hist_we;
    logic coef_we;
    logic clr_hist;
    logic clr_coef;
    logic cnt_clr;
    logic cnt_inc;
    logic issue;
    logic acc_clr;
    logic pos_clr;
    logic pos_inc;
    logic scale;
    logic out_load;
  } tsfc_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic last_clear;
    logic pipe_busy;
    logic out_busy;
  } tsfc_stat_t;

endpackage

@@ hdl/true_stereo_fir_convolver.sv @@
// Top level of the true-stereo FIR convolver: joins controller and datapath.
// Depends on tsfc_pkg, tsfc_ctrl and tsfc_datapath.
//
//   Channel  Handshake                 Payload
//   in       in_valid_i / in_ready_o   func, sample_left/right, coef_path/index/value
//   out      out_valid_o / out_ready_i out_left, out_right
//   cfg      cfg_we_i                  cfg_data_i (taps_in_use)
//
// A sample word is accepted, then the taps in use (T = taps_in_use, held to 1..256) are
// multiply-accumulated for all four paths, the pipeline drains, the sums are scaled
// and the output is loaded. A coefficient write is taken without leaving the idle state.
// After reset, and after a history clear word, a clearing pass over all 256 entries runs
// with in_ready_o low. A waiting result holds the block in its last step only.
module true_stereo_fir_convolver
  import tsfc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [TAPS_W-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                func_i,
  input  logic signed [FIELD_W-1:0] sample_left_i,
  input  logic signed [FIELD_W-1:0] sample_right_i,
  input  logic [1:0]                coef_path_i,
  input  logic [7:0]                coef_index_i,
  input  logic signed [FIELD_W-1:0] coef_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [OUT_W-1:0]   out_left_o,
  output logic signed [OUT_W-1:0]   out_right_o
);

  tsfc_cmd_t  cmd;
  tsfc_stat_t stat;

  tsfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tsfc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .coef_path_i    (coef_path_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o)
  );

endmodule

@@ hdl/tsfc_ctrl.sv @@
// Controller state machine of the convolver: decodes accepted words and
// sequences clearing, tap stepping, scaling and output. Depends on tsfc_pkg.
module tsfc_ctrl
  import tsfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] func_i,
  output logic       in_ready_o,
  input  tsfc_stat_t stat_i,
  output tsfc_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   clr_coef_q, clr_coef_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_coef_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      clr_coef_q <= clr_coef_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_coef_d = clr_coef_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_hist = 1'b1;
        cmd_o.clr_coef = clr_coef_q;
        cmd_o.cnt_inc  = 1'b1;
        if (stat_i.last_clear) begin
          clr_coef_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (func_i)
            FUNC_SAMPLE: begin
              cmd_o.hist_we = 1'b1;
              cmd_o.acc_clr = 1'b1;
              cmd_o.cnt_clr = 1'b1;
              state_d       = S_MAC;
            end
            FUNC_COEF: begin
              cmd_o.coef_we = 1'b1;
            end
            FUNC_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
              cmd_o.pos_clr = 1'b1;
              clr_coef_d    = 1'b0;
              state_d       = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_MAC: begin
        cmd_o.issue   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.last_tap) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          cmd_o.scale   = 1'b1;
          cmd_o.pos_inc = 1'b1;
          state_d       = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/tsfc_datapath.sv @@
// Datapath of the convolver: history and coefficient memories, four tap
// multipliers, two accumulators, gain stage and output register.
// Depends on tsfc_pkg.
module tsfc_datapath
  import tsfc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [TAPS_W-1:0]        cfg_data_i,
  input  logic signed [FIELD_W-1:0] sample_left_i,
  input  logic signed [FIELD_W-1:0] sample_right_i,
  input  logic [1:0]               coef_path_i,
  input  logic [7:0]               coef_index_i,
  input  logic signed [FIELD_W-1:0] coef_value_i,
  input  tsfc_cmd_t                cmd_i,
  output tsfc_stat_t               stat_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [OUT_W-1:0]  out_left_o,
  output logic signed [OUT_W-1:0]  out_right_o
);

  logic [TAPS_W-1:0] taps_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TAP_AW-1:0] pos_q;
  logic [CNT_W-1:0]  taps_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_RESET;
      cnt_q  <= '0;
      pos_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        taps_q <= cfg_data_i;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.pos_clr) begin
        pos_q <= '0;
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (taps_q == '0) begin
      taps_last = '0;
    end else if ((CNT_W + TAPS_W)'(taps_q) > (CNT_W + TAPS_W)'(MAX_TAPS)) begin
      taps_last = CNT_W'(MAX_TAPS - 1);
    end else begin
      taps_last = CNT_W'(taps_q) - 1'b1;
    end
  end

  assign stat_o.last_tap   = (cnt_q == taps_last);
  assign stat_o.last_clear = (cnt_q == CNT_W'(MAX_TAPS - 1));

  logic [TAP_AW-1:0] hist_waddr, hist_raddr, coef_addr;
  logic              hist_we;
  logic signed [SAMPLE_BITS-1:0] hl_wdata, hr_wdata, hl_rd_q, hr_rd_q;
  logic signed [SAMPLE_BITS-1:0] hist_l_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_r_mem [MAX_TAPS];

  assign hist_we    = cmd_i.hist_we || cmd_i.clr_hist;
  assign hist_waddr = cmd_i.clr_hist ? cnt_q[TAP_AW-1:0] : pos_q;
  assign hist_raddr = pos_q - cnt_q[TAP_AW-1:0];
  assign hl_wdata   = cmd_i.clr_hist ? '0 : sample_left_i[SAMPLE_BITS-1:0];
  assign hr_wdata   = cmd_i.clr_hist ? '0 : sample_right_i[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_l_mem[hist_waddr] <= hl_wdata;
      hist_r_mem[hist_waddr] <= hr_wdata;
    end
    hl_rd_q <= hist_l_mem[hist_raddr];
    hr_rd_q <= hist_r_mem[hist_raddr];
  end

  logic coef_ok;
  logic signed [COEF_BITS-1:0] coef_wdata;
  logic signed [COEF_BITS-1:0] coef_rd_q [4];

  assign coef_ok    = (CNT_W + 8)'(coef_index_i) < (CNT_W + 8)'(MAX_TAPS);
  assign coef_addr  = cmd_i.clr_coef ? cnt_q[TAP_AW-1:0] :
                      (cmd_i.coef_we ? TAP_AW'(coef_index_i) : cnt_q[TAP_AW-1:0]);
  assign coef_wdata = cmd_i.clr_coef ? '0 : coef_value_i[COEF_BITS-1:0];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic signed [COEF_BITS-1:0] coef_mem [MAX_TAPS];
    logic bank_we;

    assign bank_we = cmd_i.clr_coef ||
                     (cmd_i.coef_we && coef_ok && (coef_path_i == 2'(b)));

    always_ff @(posedge clk_i) begin
      if (bank_we) begin
        coef_mem[coef_addr] <= coef_wdata;
      end
      coef_rd_q[b] <= coef_mem[coef_addr];
    end
  end

  logic rd_v_q, p_v_q;
  logic signed [PROD_W-1:0] p_ll_q, p_lr_q, p_rl_q, p_rr_q;
  logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      p_v_q  <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.issue;
      p_v_q  <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_ll_q <= PROD_W'(coef_rd_q[PATH_LL]) * PROD_W'(hl_rd_q);
    p_lr_q <= PROD_W'(coef_rd_q[PATH_LR]) * PROD_W'(hl_rd_q);
    p_rl_q <= PROD_W'(coef_rd_q[PATH_RL]) * PROD_W'(hr_rd_q);
    p_rr_q <= PROD_W'(coef_rd_q[PATH_RR]) * PROD_W'(hr_rd_q);
    if (cmd_i.acc_clr) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (p_v_q) begin
      acc_l_q <= acc_l_q + ACC_W'(p_ll_q) + ACC_W'(p_rl_q);
      acc_r_q <= acc_r_q + ACC_W'(p_rr_q) + ACC_W'(p_lr_q);
    end
  end

  assign stat_o.pipe_busy = rd_v_q || p_v_q;

  logic signed [SCALED_W-1:0]  scl_l_q, scl_r_q;
  logic signed [SHIFTED_W-1:0] sh_l, sh_r;
  logic signed [OUT_W-1:0]     sat_l, sat_r;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      scl_l_q <= SCALED_W'(acc_l_q) * SCALED_W'(GAIN_Q15);
      scl_r_q <= SCALED_W'(acc_r_q) * SCALED_W'(GAIN_Q15);
    end
  end

  function automatic logic signed [OUT_W-1:0] saturate(logic signed [SHIFTED_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SHIFTED_W'(2 ** (OUT_W - 1) - 1)) begin
      r = {1'b0, {(OUT_W - 1){1'b1}}};
    end else if (v < -SHIFTED_W'(2 ** (OUT_W - 1))) begin
      r = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  assign sh_l  = SHIFTED_W'(scl_l_q >>> OUT_SHIFT);
  assign sh_r  = SHIFTED_W'(scl_r_q >>> OUT_SHIFT);
  assign sat_l = saturate(sh_l);
  assign sat_r = saturate(sh_r);

  logic out_valid_q;
  logic signed [OUT_W-1:0] out_left_q, out_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_left_q  <= sat_l;
      out_right_q <= sat_r;
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_left_o      = out_left_q;
  assign out_right_o     = out_right_q;

endmodule
